// File: rtl/pbeq_pkg.sv
// shared constants, codes and control types for the panel button and encoder qualifier
package pbeq_pkg;

	localparam int OPCODE_W = 3;
	localparam int TIME_W   = 32;
	localparam int POS_W    = 32;
	localparam int EVENT_W  = 2;
	localparam int DELTA_W  = 16;
	localparam int DIV_W    = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int CLICK_COUNT_MAX_DEF = 255;

	// each step retires two quotient bits
	localparam int DIV_BITS_PER_STEP = 2;
	localparam int DIV_STEPS         = POS_W / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

	localparam logic [OPCODE_W-1:0] OP_ENC_EDGE      = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ESC_EDGE      = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POSITION      = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_CONSUME_DELTA = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CONSUME_EVENT = 3'd4;

	localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
	localparam logic [EVENT_W-1:0] EV_ENC  = 2'd1;
	localparam logic [EVENT_W-1:0] EV_ESC  = 2'd2;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_DIVIDER  = 1'b1;

	localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd5000;
	localparam logic [DIV_W-1:0]  DIVIDER_RESET  = 5'd4;

	typedef struct packed {
		logic load;
		logic exec;
		logic div_start;
		logic div_step;
		logic div_finish;
	} pbeq_cmd_t;

	typedef struct packed {
		logic is_pos;
		logic is_consume;
		logic out_blocked;
	} pbeq_sts_t;

endpackage

// File: rtl/pbeq_ifs.sv
// valid/ready channel interfaces for input and result items
interface pbeq_in_if import pbeq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic                       pressed;
	logic [TIME_W-1:0]          time_us;
	logic signed [POS_W-1:0]    raw_position;

	modport source (output valid, opcode, pressed, time_us, raw_position, input ready);
	modport sink (input valid, opcode, pressed, time_us, raw_position, output ready);
endinterface

interface pbeq_out_if import pbeq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [EVENT_W-1:0]         event_res;
	logic signed [DELTA_W-1:0]  delta;

	modport source (output valid, event_res, delta, input ready);
	modport sink (input valid, event_res, delta, output ready);
endinterface

// File: rtl/pbeq_regs.sv
// apb configuration registers: lockout window and position divider
module pbeq_regs import pbeq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	output logic [TIME_W-1:0]   debounce_us,
	output logic [DIV_W-1:0]    position_divider
);

	logic [TIME_W-1:0] debounce_q;
	logic [DIV_W-1:0]  divider_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			divider_q  <= DIVIDER_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DEBOUNCE: debounce_q <= pwdata[TIME_W-1:0];
				REG_DIVIDER:  divider_q  <= pwdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = debounce_q;
			REG_DIVIDER:  prdata = {{(APB_DW-DIV_W){1'b0}}, divider_q};
			default:      prdata = '0;
		endcase
	end

	assign debounce_us      = debounce_q;
	assign position_divider = divider_q;

endmodule

// File: rtl/pbeq_ctrl.sv
// controller state machine: item intake, execution and divider sequencing
module pbeq_ctrl import pbeq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pbeq_sts_t sts,
	output pbeq_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.is_pos) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (!(sts.is_consume && sts.out_blocked)) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.div_finish = 1'b1;
				state_d        = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// File: rtl/pbeq_dp.sv
// datapath: button qualifiers, click counters, iterative divider, delta and result register
module pbeq_dp import pbeq_pkg::*; #(
	parameter int CLICK_COUNT_MAX = CLICK_COUNT_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic                       pressed,
	input  logic [TIME_W-1:0]          time_us,
	input  logic signed [POS_W-1:0]    raw_position,
	input  logic [TIME_W-1:0]          debounce_us,
	input  logic [DIV_W-1:0]           position_divider,
	input  pbeq_cmd_t                  cmd,
	output pbeq_sts_t                  sts,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [EVENT_W-1:0]         event_res,
	output logic signed [DELTA_W-1:0]  delta
);

	localparam int CNT_W = $clog2(CLICK_COUNT_MAX + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CLICK_COUNT_MAX);

	// item register
	logic [OPCODE_W-1:0] op_q;
	logic                pressed_q;
	logic [TIME_W-1:0]   time_q;
	logic [POS_W-1:0]    raw_q;

	// qualifier state
	logic              enc_held_q, esc_held_q;
	logic [TIME_W-1:0] enc_last_q, esc_last_q;
	logic [CNT_W-1:0]  enc_cnt_q, esc_cnt_q;
	logic [POS_W-1:0]  last_step_q;
	logic [DELTA_W-1:0] pending_q;

	// divider
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  rem_q;
	logic [POS_W-1:0]  mag_q;
	logic              neg_q;
	logic [DIV_W:0]    r1_ext, r2_ext;
	logic [DIV_W-1:0]  r1, r2;
	logic              b1, b2;
	logic [POS_W-1:0]  quot;

	// result register
	logic                out_valid_q;
	logic [EVENT_W-1:0]  event_q;
	logic [DELTA_W-1:0]  delta_q;

	logic enc_open, esc_open;

	assign sts.is_pos      = (op_q == OP_POSITION);
	assign sts.is_consume  = (op_q == OP_CONSUME_DELTA) || (op_q == OP_CONSUME_EVENT);
	assign sts.out_blocked = out_valid_q & ~out_ready;

	assign enc_open = (time_q - enc_last_q) >= debounce_us;
	assign esc_open = (time_q - esc_last_q) >= debounce_us;

	// two restoring steps per cycle
	always_comb begin
		r1_ext = {rem_q, mag_q[POS_W-1]};
		b1     = r1_ext >= {1'b0, div_q};
		r1     = b1 ? DIV_W'(r1_ext - {1'b0, div_q}) : r1_ext[DIV_W-1:0];
		r2_ext = {r1, mag_q[POS_W-2]};
		b2     = r2_ext >= {1'b0, div_q};
		r2     = b2 ? DIV_W'(r2_ext - {1'b0, div_q}) : r2_ext[DIV_W-1:0];
	end

	assign quot = neg_q ? (~mag_q + 1'b1) : mag_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			pressed_q <= pressed;
			time_q    <= time_us;
			raw_q     <= raw_position;
		end
		if (cmd.div_start) begin
			div_q <= (position_divider == '0) ? DIV_W'(1) : position_divider;
			rem_q <= '0;
			neg_q <= raw_q[POS_W-1];
			mag_q <= raw_q[POS_W-1] ? (~raw_q + 1'b1) : raw_q;
		end else if (cmd.div_step) begin
			rem_q <= r2;
			mag_q <= {mag_q[POS_W-3:0], b1, b2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_held_q  <= 1'b0;
			esc_held_q  <= 1'b0;
			enc_last_q  <= '0;
			esc_last_q  <= '0;
			enc_cnt_q   <= '0;
			esc_cnt_q   <= '0;
			last_step_q <= '0;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && sts.is_consume) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.div_finish) begin
				last_step_q <= quot;
				pending_q   <= pending_q + quot[DELTA_W-1:0] - last_step_q[DELTA_W-1:0];
			end
			if (cmd.exec) begin
				unique case (op_q)
					OP_ENC_EDGE: begin
						if (enc_open) begin
							enc_last_q <= time_q;
							if (pressed_q) begin
								enc_held_q <= 1'b1;
							end else if (enc_held_q) begin
								enc_held_q <= 1'b0;
								if (enc_cnt_q != CNT_MAX) enc_cnt_q <= enc_cnt_q + 1'b1;
							end
						end
					end
					OP_ESC_EDGE: begin
						if (esc_open) begin
							esc_last_q <= time_q;
							if (pressed_q) begin
								esc_held_q <= 1'b1;
							end else if (esc_held_q) begin
								esc_held_q <= 1'b0;
								if (esc_cnt_q != CNT_MAX) esc_cnt_q <= esc_cnt_q + 1'b1;
							end
						end
					end
					OP_CONSUME_DELTA: begin
						pending_q <= '0;
					end
					OP_CONSUME_EVENT: begin
						if (enc_cnt_q != '0) enc_cnt_q <= enc_cnt_q - 1'b1;
						else if (esc_cnt_q != '0) esc_cnt_q <= esc_cnt_q - 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_CONSUME_DELTA) begin
			event_q <= EV_NONE;
			delta_q <= pending_q;
		end else if (cmd.exec && op_q == OP_CONSUME_EVENT) begin
			delta_q <= '0;
			if (enc_cnt_q != '0) event_q <= EV_ENC;
			else if (esc_cnt_q != '0) event_q <= EV_ESC;
			else event_q <= EV_NONE;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign delta     = delta_q;

endmodule

// File: rtl/panel_button_encoder_qualifier_unit.sv
// top level: apb registers, controller and datapath of the button and encoder qualifier
// execution: each item is loaded on accept and run in the EXEC state; a consume item
// sets a result, but stays in EXEC while an earlier result waits in the output register
// position update: EXEC, then the 16 steps of the radix-4 divider in DIV, then FIN
// intake: no new item is taken until the current item or position update is done
// reset: arst_n clears held flags, edge times, counts, delta and the result valid flag
module panel_button_encoder_qualifier_unit import pbeq_pkg::*; #(
	parameter int CLICK_COUNT_MAX = CLICK_COUNT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pbeq_in_if.sink           in_item,
	pbeq_out_if.source        out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [TIME_W-1:0] debounce_us;
	logic [DIV_W-1:0]  position_divider;
	pbeq_cmd_t         cmd;
	pbeq_sts_t         sts;

	pbeq_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.debounce_us      (debounce_us),
		.position_divider (position_divider)
	);

	pbeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_ready (in_item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbeq_dp #(
		.CLICK_COUNT_MAX (CLICK_COUNT_MAX)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.opcode           (in_item.opcode),
		.pressed          (in_item.pressed),
		.time_us          (in_item.time_us),
		.raw_position     (in_item.raw_position),
		.debounce_us      (debounce_us),
		.position_divider (position_divider),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (out_item.ready),
		.out_valid        (out_item.valid),
		.event_res        (out_item.event_res),
		.delta            (out_item.delta)
	);

endmodule

// File: rtl/pbeq_checker.sv
// port-level checker for the qualifier top level and its bind
module pbeq_checker import pbeq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [OPCODE_W-1:0] in_opcode,
	input logic                out_valid,
	input logic                out_ready,
	input logic [EVENT_W-1:0]  out_event,
	input logic [DELTA_W-1:0]  out_delta
);

	// a waiting result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_delta))
		else $error("result dropped or changed while stalled");

	// one item in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while another is in flight");

	// a fresh result comes from an accepted consume item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) &&
			($past(in_opcode, 2) == OP_CONSUME_DELTA || $past(in_opcode, 2) == OP_CONSUME_EVENT))
		else $error("result without a consume item");

	// a result carries either an event or a delta, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_event == EV_NONE || out_delta == '0) &&
			(out_event == EV_NONE || out_event == EV_ENC || out_event == EV_ESC))
		else $error("malformed result");

endmodule

bind panel_button_encoder_qualifier_unit pbeq_checker u_pbeq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_item.valid),
	.in_ready  (in_item.ready),
	.in_opcode (in_item.opcode),
	.out_valid (out_item.valid),
	.out_ready (out_item.ready),
	.out_event (out_item.event_res),
	.out_delta (out_item.delta)
);
